### rtl/lidar_temporal_point_filter_top_assert.svh
// Assertion macros shared by the point filter RTL.
`ifndef LIDAR_TEMPORAL_POINT_FILTER_TOP_ASSERT_SVH
`define LIDAR_TEMPORAL_POINT_FILTER_TOP_ASSERT_SVH
// Same-cycle implication, checked on every clock edge outside reset.
`define LTPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define LTPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/ltpf_pkg.sv
// Package: constants, types and helper functions of the point filter.
package ltpf_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int ANGLE_BINS   = 2000;
    localparam int MAX_DEPTH    = 10;
    localparam int DIST_BITS    = 16;

    localparam int ANGLE_STEP   = 20;
    localparam int VAR_LIMIT    = 2000;
    localparam int RANGE_FACTOR = 10;
    localparam int DIFF_LIMIT   = 1024;

    // bin = angle / ANGLE_STEP as a multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT  = 20;
    localparam int ANGLE_RECIP  = ((1 << RECIP_SHIFT) + ANGLE_STEP - 1) / ANGLE_STEP;
    localparam int ANGLE_W      = 16;
    localparam int RECIP_W      = $clog2(ANGLE_RECIP + 1);
    localparam int RPROD_W      = ANGLE_W + RECIP_W;

    localparam int NUM_BINS     = MAX_CHANNELS * ANGLE_BINS;
    localparam int HIST_ENTRIES = NUM_BINS * MAX_DEPTH;
    localparam int BIN_W        = $clog2(ANGLE_BINS);
    localparam int IDX_W        = $clog2(NUM_BINS);
    localparam int HADDR_W      = $clog2(HIST_ENTRIES);
    localparam int SLOT_W       = $clog2(MAX_DEPTH);
    localparam int DEPTH_W      = $clog2(MAX_DEPTH + 1);
    localparam int CH_W         = 4;
    localparam int NCH_W        = 5;
    localparam int FRAME_W      = 16;
    localparam int STAMP_W      = 8;
    localparam int FSS_W        = 5;

    localparam int SUM_W        = DIST_BITS + $clog2(MAX_DEPTH + 1);
    localparam int SQSUM_W      = 2 * DIST_BITS + $clog2(MAX_DEPTH + 1);
    localparam int PROD_W       = 2 * SUM_W;
    localparam int THR_W        = $clog2(VAR_LIMIT * MAX_DEPTH * MAX_DEPTH + 1);

    localparam logic [1:0] CMD_POINT   = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_NUM_CH   = 2'd1;
    localparam logic [1:0] REG_DEPTH    = 2'd2;

    typedef struct packed {
        logic                  slot_valid;
        logic [SLOT_W-1:0]     ptr;
        logic [MAX_DEPTH-1:0]  written;
    } meta_t;

    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] stamp;
    } stamp_t;

    typedef struct packed {
        logic                 start;
        logic                 smp_valid;
        logic                 finish;
        logic [DIST_BITS-1:0] smp;
        logic [DEPTH_W-1:0]   depth;
    } st_req_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic steady;
    } st_rsp_t;

    function automatic logic [DEPTH_W-1:0] eff_depth(input logic [3:0] d);
        logic [DEPTH_W-1:0] r;
        if (d == 4'd0)
            r = DEPTH_W'(1);
        else if (32'(d) > MAX_DEPTH)
            r = DEPTH_W'(MAX_DEPTH);
        else
            r = DEPTH_W'(d);
        return r;
    endfunction

    function automatic logic [THR_W-1:0] var_thr(input logic [DEPTH_W-1:0] d);
        return THR_W'(VAR_LIMIT * 32'(d) * 32'(d));
    endfunction

endpackage

### rtl/ltpf_steady.sv
// Steadiness judge: accumulates history samples through one shared multiplier.
`include "lidar_temporal_point_filter_top_assert.svh"
module ltpf_steady
(
    input  logic             clk,
    input  logic             rst_n,
    input  ltpf_pkg::st_req_t req,
    output ltpf_pkg::st_rsp_t rsp
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_SUMSQ, S_DMUL, S_CMP} st_state_t;

    st_state_t                         state_reg;
    logic [ltpf_pkg::DIST_BITS-1:0]    x_reg;
    logic [ltpf_pkg::DIST_BITS-1:0]    mn_reg;
    logic [ltpf_pkg::DIST_BITS-1:0]    mx_reg;
    logic [ltpf_pkg::SUM_W-1:0]        sum_reg;
    logic [ltpf_pkg::SQSUM_W-1:0]      sumsq_reg;
    logic [ltpf_pkg::PROD_W-1:0]       prod_reg;
    logic [ltpf_pkg::PROD_W-1:0]       dsq_reg;
    logic [ltpf_pkg::DEPTH_W-1:0]      cnt_reg;
    logic [ltpf_pkg::DEPTH_W-1:0]      depth_reg;
    logic                              done_reg;
    logic                              steady_reg;

    logic [ltpf_pkg::SUM_W-1:0]        mul_a;
    logic [ltpf_pkg::PROD_W-1:0]       mul_p;
    logic [ltpf_pkg::DIST_BITS-1:0]    range;
    logic [ltpf_pkg::DIST_BITS+3:0]    range10;

    // shared squarer: a sample, or the running sum at the end
    assign mul_a   = (state_reg == S_MUL) ? ltpf_pkg::SUM_W'(x_reg) : sum_reg;
    assign mul_p   = mul_a * mul_a;
    assign range   = mx_reg - mn_reg;
    assign range10 = ({4'd0, range} << 3) + ({4'd0, range} << 1);

    assign rsp.ready  = (state_reg == S_IDLE);
    assign rsp.done   = done_reg;
    assign rsp.steady = steady_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            steady_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        sum_reg   <= '0;
                        sumsq_reg <= '0;
                        mn_reg    <= '1;
                        mx_reg    <= '0;
                        depth_reg <= req.depth;
                    end
                    else if (req.smp_valid)
                    begin
                        x_reg   <= req.smp;
                        sum_reg <= sum_reg + ltpf_pkg::SUM_W'(req.smp);
                        if (req.smp < mn_reg)
                            mn_reg <= req.smp;
                        if (req.smp > mx_reg)
                            mx_reg <= req.smp;
                        state_reg <= S_MUL;
                    end
                    else if (req.finish)
                    begin
                        cnt_reg   <= depth_reg;
                        dsq_reg   <= '0;
                        state_reg <= S_SUMSQ;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sumsq_reg <= sumsq_reg + prod_reg[ltpf_pkg::SQSUM_W-1:0];
                    state_reg <= S_IDLE;
                end
                S_SUMSQ:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_DMUL;
                end
                S_DMUL:
                begin
                    // depth * sum of squares by repeated add
                    dsq_reg <= dsq_reg + ltpf_pkg::PROD_W'(sumsq_reg);
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg <= ltpf_pkg::DEPTH_W'(1))
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    steady_reg <= (32'(range) <= ltpf_pkg::DIFF_LIMIT)
                        && ((dsq_reg - prod_reg)
                            < ltpf_pkg::PROD_W'(ltpf_pkg::var_thr(depth_reg)))
                        && (range10 < {4'd0, mn_reg});
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `LTPF_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result outside idle")
    `LTPF_ASSERT_NEXT(a_cmp_done, state_reg == S_CMP, done_reg, "judge result lost")
    `LTPF_ASSERT_NEXT(a_mul_acc, state_reg == S_MUL, state_reg == S_ACC, "square not added")

endmodule

### rtl/lidar_temporal_point_filter_top.sv
// Top level of the temporal LiDAR point filter.
// Usage:
//   in channel  (in_valid/in_ready): one request carries cmd, frame_start,
//     frame_index, channel, angle_h and distance. cmd point yields one result;
//     restart warm-up, clear histories and the unused code yield none.
//   out channel (out_valid/out_ready): keep, error and the echoed point.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//     a write to enable, num_channels or filter_depth clears all histories.
// Sequence: a disabled point goes straight to the result; a bad channel
//   after the channel check; a point in warm-up after the bin, index,
//   metadata read and update states; a judged point then reads, feeds and
//   awaits each history slot, then the final sums; the single history read
//   port and shared squarer in ltpf_steady pace it. One request at a time.
// Reset and clearing: bin metadata is cleared by a sweep over all 32000 bins
//   (one bin per cycle) after reset, after a config write and on a clear
//   request; a frame stamp wrap runs the same sweep over the stamps only.
//   in_ready stays low meanwhile. History words are never swept: a bin
//   carries a written mask and unwritten slots read as zero.
// Stall: a finished result sits in the output register; the next request
//   is taken meanwhile and its result waits until the register frees.
`include "lidar_temporal_point_filter_top_assert.svh"
module lidar_temporal_point_filter_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic                          frame_start,
    input  logic [ltpf_pkg::FRAME_W-1:0]  frame_index,
    input  logic [ltpf_pkg::CH_W-1:0]     channel,
    input  logic [ltpf_pkg::ANGLE_W-1:0]  angle_h,
    input  logic [ltpf_pkg::DIST_BITS-1:0] distance,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          keep,
    output logic                          error,
    output logic [ltpf_pkg::CH_W-1:0]     out_channel,
    output logic [ltpf_pkg::ANGLE_W-1:0]  out_angle_h,
    output logic [ltpf_pkg::DIST_BITS-1:0] out_distance,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [ltpf_pkg::NCH_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        T_SWEEP, T_IDLE, T_CHK, T_BIN, T_IDX, T_MRD, T_UPD,
        T_HRD, T_HFEED, T_HWAIT, T_HFIN, T_HJUDGE, T_RES
    } top_state_t;

    top_state_t                          state_reg;

    // configuration
    logic                                enable_reg;
    logic [ltpf_pkg::NCH_W-1:0]          num_ch_reg;
    logic [3:0]                          depth_cfg_reg;

    // frame tracking
    logic [ltpf_pkg::STAMP_W-1:0]        frame_stamp_reg;
    logic [ltpf_pkg::FSS_W-1:0]          fss_reg;
    logic [ltpf_pkg::FRAME_W-1:0]        last_fi_reg;

    // sweep control
    logic [ltpf_pkg::IDX_W-1:0]          sweep_cnt_reg;
    logic                                sweep_full_reg;
    logic                                resume_reg;

    // captured point and work registers
    logic [ltpf_pkg::CH_W-1:0]           ch_reg;
    logic [ltpf_pkg::ANGLE_W-1:0]        ang_reg;
    logic [ltpf_pkg::DIST_BITS-1:0]      dist_reg;
    logic [ltpf_pkg::RPROD_W-1:0]        rprod_reg;
    logic [ltpf_pkg::IDX_W-1:0]          idx_reg;
    logic [ltpf_pkg::HADDR_W-1:0]        base_reg;
    logic [ltpf_pkg::MAX_DEPTH-1:0]      mask_reg;
    logic [ltpf_pkg::DEPTH_W-1:0]        i_reg;

    // result register
    logic                                out_valid_reg;
    logic                                keep_reg;
    logic                                error_reg;
    logic [ltpf_pkg::CH_W-1:0]           out_ch_reg;
    logic [ltpf_pkg::ANGLE_W-1:0]        out_ang_reg;
    logic [ltpf_pkg::DIST_BITS-1:0]      out_dist_reg;
    logic                                res_keep_reg;
    logic                                res_err_reg;

    // memories
    ltpf_pkg::meta_t                     meta_mem [ltpf_pkg::NUM_BINS];
    ltpf_pkg::stamp_t                    stamp_mem [ltpf_pkg::NUM_BINS];
    logic [ltpf_pkg::DIST_BITS-1:0]      hist_mem [ltpf_pkg::HIST_ENTRIES];
    ltpf_pkg::meta_t                     meta_q_reg;
    ltpf_pkg::stamp_t                    stamp_q_reg;
    logic [ltpf_pkg::DIST_BITS-1:0]      hist_q_reg;

    // combinational
    logic [ltpf_pkg::DEPTH_W-1:0]        depth_eff;
    logic [ltpf_pkg::NCH_W-1:0]          ch_eff;
    logic [ltpf_pkg::FRAME_W-1:0]        fi_diff;
    logic [ltpf_pkg::STAMP_W-1:0]        stamp_inc;
    logic [ltpf_pkg::RPROD_W-ltpf_pkg::RECIP_SHIFT-1:0] bin_raw;
    logic [ltpf_pkg::BIN_W-1:0]          bin;
    logic                                fresh;
    logic [ltpf_pkg::SLOT_W:0]           ptr_inc;
    logic [ltpf_pkg::SLOT_W-1:0]         new_ptr;
    logic [ltpf_pkg::SLOT_W-1:0]         eff_slot;
    ltpf_pkg::meta_t                     new_meta;
    logic                                meta_we;
    logic [ltpf_pkg::IDX_W-1:0]          meta_waddr;
    ltpf_pkg::meta_t                     meta_wdata;
    logic                                stamp_we;
    ltpf_pkg::stamp_t                    stamp_wdata;
    logic                                hist_we;
    logic [ltpf_pkg::HADDR_W-1:0]        hist_waddr;
    logic [ltpf_pkg::HADDR_W-1:0]        hist_raddr;
    logic                                warm;

    ltpf_pkg::st_req_t                   st_req;
    ltpf_pkg::st_rsp_t                   st_rsp;

    assign depth_eff = ltpf_pkg::eff_depth(depth_cfg_reg);
    assign ch_eff    = (32'(num_ch_reg) > ltpf_pkg::MAX_CHANNELS)
                       ? ltpf_pkg::NCH_W'(ltpf_pkg::MAX_CHANNELS) : num_ch_reg;
    assign fi_diff   = (frame_index > last_fi_reg) ? frame_index - last_fi_reg
                                                   : last_fi_reg - frame_index;
    assign stamp_inc = frame_stamp_reg + 1'b1;

    // angle bin, clamped to the last bin
    assign bin_raw = rprod_reg[ltpf_pkg::RPROD_W-1:ltpf_pkg::RECIP_SHIFT];
    assign bin     = (32'(bin_raw) >= ltpf_pkg::ANGLE_BINS)
                     ? ltpf_pkg::BIN_W'(ltpf_pkg::ANGLE_BINS - 1)
                     : ltpf_pkg::BIN_W'(bin_raw);

    // slot advance, at most once per frame
    assign fresh   = !(stamp_q_reg.valid && (stamp_q_reg.stamp == frame_stamp_reg));
    assign ptr_inc = {1'b0, meta_q_reg.ptr} + 1'b1;
    always_comb
    begin
        if (fresh)
        begin
            if (meta_q_reg.slot_valid && (32'(ptr_inc) < 32'(depth_eff)))
                new_ptr = ptr_inc[ltpf_pkg::SLOT_W-1:0];
            else
                new_ptr = '0;
        end
        else
            new_ptr = meta_q_reg.ptr;
        eff_slot = (32'(new_ptr) >= 32'(depth_eff)) ? '0 : new_ptr;
        new_meta.slot_valid = 1'b1;
        new_meta.ptr        = new_ptr;
        new_meta.written    = meta_q_reg.written
                              | (ltpf_pkg::MAX_DEPTH'(1) << eff_slot);
    end

    assign warm = (32'(fss_reg) <= 32'(depth_eff));

    // memory port selection
    assign meta_we     = ((state_reg == T_SWEEP) && sweep_full_reg) || (state_reg == T_UPD);
    assign meta_waddr  = (state_reg == T_SWEEP) ? sweep_cnt_reg : idx_reg;
    assign meta_wdata  = (state_reg == T_SWEEP) ? '0 : new_meta;
    assign stamp_we    = (state_reg == T_SWEEP) || ((state_reg == T_UPD) && fresh);
    assign stamp_wdata = (state_reg == T_SWEEP) ? '0 : {1'b1, frame_stamp_reg};
    assign hist_we     = (state_reg == T_UPD);
    assign hist_waddr  = base_reg + ltpf_pkg::HADDR_W'(eff_slot);
    assign hist_raddr  = base_reg + ltpf_pkg::HADDR_W'(i_reg);

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        meta_q_reg <= meta_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
            stamp_mem[meta_waddr] <= stamp_wdata;
        stamp_q_reg <= stamp_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= dist_reg;
        hist_q_reg <= hist_mem[hist_raddr];
    end

    // steadiness judge
    assign st_req.start     = (state_reg == T_UPD) && !warm;
    assign st_req.smp_valid = (state_reg == T_HFEED);
    assign st_req.finish    = (state_reg == T_HFIN);
    assign st_req.smp       = mask_reg[i_reg[ltpf_pkg::SLOT_W-1:0]] ? hist_q_reg : '0;
    assign st_req.depth     = depth_eff;

    ltpf_steady u_steady
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (st_req),
        .rsp   (st_rsp)
    );

    assign in_ready     = (state_reg == T_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign keep         = keep_reg;
    assign error        = error_reg;
    assign out_channel  = out_ch_reg;
    assign out_angle_h  = out_ang_reg;
    assign out_distance = out_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_SWEEP;
            enable_reg      <= 1'b0;
            num_ch_reg      <= ltpf_pkg::NCH_W'(16);
            depth_cfg_reg   <= 4'd5;
            frame_stamp_reg <= '0;
            fss_reg         <= '0;
            last_fi_reg     <= '0;
            sweep_cnt_reg   <= '0;
            sweep_full_reg  <= 1'b1;
            resume_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // drop the result once taken
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                T_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                    if (32'(sweep_cnt_reg) == ltpf_pkg::NUM_BINS - 1)
                        state_reg <= resume_reg ? T_CHK : T_IDLE;
                end
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        ch_reg   <= channel;
                        ang_reg  <= angle_h;
                        dist_reg <= distance;
                        case (cmd)
                            ltpf_pkg::CMD_RESTART:
                                fss_reg <= '0;
                            ltpf_pkg::CMD_CLEAR:
                            begin
                                sweep_cnt_reg  <= '0;
                                sweep_full_reg <= 1'b1;
                                resume_reg     <= 1'b0;
                                state_reg      <= T_SWEEP;
                            end
                            ltpf_pkg::CMD_POINT:
                            begin
                                if (!enable_reg)
                                begin
                                    res_keep_reg <= 1'b0;
                                    res_err_reg  <= 1'b1;
                                    state_reg    <= T_RES;
                                end
                                else
                                begin
                                    state_reg <= T_CHK;
                                    if (frame_start)
                                    begin
                                        // restart warm-up on a large frame jump
                                        if ((fi_diff >= ltpf_pkg::FRAME_W'(depth_eff))
                                            || (fss_reg == '1))
                                            fss_reg <= (fi_diff >= ltpf_pkg::FRAME_W'(depth_eff))
                                                       ? ltpf_pkg::FSS_W'(1) : fss_reg;
                                        else
                                            fss_reg <= fss_reg + 1'b1;
                                        last_fi_reg     <= frame_index;
                                        frame_stamp_reg <= stamp_inc;
                                        if (stamp_inc == '0)
                                        begin
                                            // stamps wrapped: invalidate all bin stamps
                                            sweep_cnt_reg  <= '0;
                                            sweep_full_reg <= 1'b0;
                                            resume_reg     <= 1'b1;
                                            state_reg      <= T_SWEEP;
                                        end
                                    end
                                end
                            end
                            default:
                                state_reg <= T_IDLE;
                        endcase
                    end
                end
                T_CHK:
                begin
                    if ({1'b0, ch_reg} >= ch_eff)
                    begin
                        res_keep_reg <= 1'b0;
                        res_err_reg  <= 1'b1;
                        state_reg    <= T_RES;
                    end
                    else
                    begin
                        rprod_reg <= ltpf_pkg::RPROD_W'(ang_reg)
                                     * ltpf_pkg::RPROD_W'(ltpf_pkg::ANGLE_RECIP);
                        state_reg <= T_BIN;
                    end
                end
                T_BIN:
                begin
                    idx_reg <= ltpf_pkg::IDX_W'(32'(ch_reg) * ltpf_pkg::ANGLE_BINS)
                               + ltpf_pkg::IDX_W'(bin);
                    state_reg <= T_IDX;
                end
                T_IDX:
                begin
                    // metadata read issues this cycle
                    base_reg  <= ltpf_pkg::HADDR_W'(32'(idx_reg) * ltpf_pkg::MAX_DEPTH);
                    state_reg <= T_MRD;
                end
                T_MRD:
                    state_reg <= T_UPD;
                T_UPD:
                begin
                    mask_reg <= new_meta.written;
                    i_reg    <= '0;
                    if (warm)
                    begin
                        res_keep_reg <= 1'b1;
                        res_err_reg  <= 1'b0;
                        state_reg    <= T_RES;
                    end
                    else
                        state_reg <= T_HRD;
                end
                T_HRD:
                    state_reg <= T_HFEED;
                T_HFEED:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= T_HWAIT;
                end
                T_HWAIT:
                begin
                    if (st_rsp.ready)
                        state_reg <= (i_reg == depth_eff) ? T_HFIN : T_HRD;
                end
                T_HFIN:
                    state_reg <= T_HJUDGE;
                T_HJUDGE:
                begin
                    if (st_rsp.done)
                    begin
                        res_keep_reg <= st_rsp.steady;
                        res_err_reg  <= 1'b0;
                        state_reg    <= T_RES;
                    end
                end
                T_RES:
                begin
                    // hold until the output register frees
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        keep_reg      <= res_keep_reg;
                        error_reg     <= res_err_reg;
                        out_ch_reg    <= ch_reg;
                        out_ang_reg   <= ang_reg;
                        out_dist_reg  <= dist_reg;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                    state_reg <= T_IDLE;
            endcase

            // configuration write to a defined index: update and clear histories
            if (cfg_valid)
            begin
                case (cfg_index)
                    ltpf_pkg::REG_ENABLE: enable_reg    <= cfg_data[0];
                    ltpf_pkg::REG_NUM_CH: num_ch_reg    <= cfg_data;
                    ltpf_pkg::REG_DEPTH:  depth_cfg_reg <= cfg_data[3:0];
                    default:              enable_reg    <= enable_reg;
                endcase
                if ((cfg_index == ltpf_pkg::REG_ENABLE) || (cfg_index == ltpf_pkg::REG_NUM_CH)
                    || (cfg_index == ltpf_pkg::REG_DEPTH))
                begin
                    sweep_cnt_reg  <= '0;
                    sweep_full_reg <= 1'b1;
                    resume_reg     <= 1'b0;
                    state_reg      <= T_SWEEP;
                end
            end
        end
    end

    `LTPF_ASSERT_NOW(a_err_no_keep, out_valid_reg, !(keep_reg && error_reg), "kept error point")
    `LTPF_ASSERT_NOW(a_slot_range, hist_we, 32'(eff_slot) < 32'(depth_eff), "slot beyond depth")
    `LTPF_ASSERT_NOW(a_judge_idle, st_req.smp_valid, st_rsp.ready, "sample to busy judge")

endmodule
